// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check of a property on the rising clock edge, off during reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Concurrent check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	`ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons))

`endif

// ----- rtl/lef_pkg.sv -----
// Types, codes and kernel arithmetic of the Laplacian edge filter.
`default_nettype none

package lef_pkg;

	localparam int PIX_W = 24;

	// Item kinds on the input tuser.
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// Register indexes on the configuration channel.
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;

	// Control that travels with an item from acceptance to the output register.
	typedef struct packed {
		logic is_pix;
		logic emit;
		logic interior;
		logic last;
	} lef_ctl_t;

	// 8 * centre minus the sum of eight neighbours, clamped to 0..255.
	function automatic logic [7:0] lap_chan(input logic [7:0] ctr, input logic [63:0] nbrs);
		logic [10:0]        sum;
		logic signed [12:0] acc;
		sum = '0;
		for (int i = 0; i < 8; i++) begin
			sum = sum + {3'b000, nbrs[8*i +: 8]};
		end
		acc = $signed({2'b00, ctr, 3'b000}) - $signed({2'b00, sum});
		if (acc < 0) begin
			return 8'd0;
		end else if (acc > 13'sd255) begin
			return 8'd255;
		end
		return acc[7:0];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/lef_ram.sv -----
// Generic single-clock RAM: one write port, one read port with registered data.
`default_nettype none

module lef_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire                      re,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/laplacian_edge_filter_rgb.sv -----
// Top level of the 3x3 Laplacian edge filter for an RGB pixel stream.
//
// Input stream s_axis: tdata carries one pixel, tuser the item kind (pixel or
// drain). Output stream m_axis: tdata carries the filtered pixel, tlast marks
// the last result of a frame. Configuration channel cfg_*: register 0 is the
// frame width, register 1 the height; a write to either restarts the frame.
// A pixel beat enters a two-stage path: the line store RAM is read in the
// accept cycle; when the second stage advances, it writes the row back,
// shifts the 3x3 window and computes the kernel into the output register.
// A result trails the input by width+1 pixels in stream terms.
// After the frame, width+1 zero border results wait; each drain beat sends one.
// Throughput is one beat per cycle while m_axis does not stall, bounded by
// the single line store port pair. Reset clears the position counters, the
// stage and output valid and control bits and the window; data registers
// and line store contents are not cleared. When m_axis stalls, the output
// register holds and s_axis_tready stays high only while stage two is empty.
`default_nettype none

module laplacian_edge_filter_rgb #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire         clk,
	input  wire         arst_n,
	// input stream
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [23:0] s_axis_tdata,  // red_in[7:0], green_in[15:8], blue_in[23:16]
	input  wire         s_axis_tuser,  // op[0]
	// output stream
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [23:0] m_axis_tdata,  // red_out[7:0], green_out[15:8], blue_out[23:16]
	output logic        m_axis_tlast,  // frame_end
	// configuration writes
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [11:0] cfg_data
);

	import lef_pkg::*;

	`include "assert_macros.svh"

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int PW   = $clog2(MAX_WIDTH + 2);
	localparam int CMPW = (WW > 11) ? WW : 11;

	logic [10:0]        frame_width_q;
	logic [11:0]        frame_height_q;
	logic [CW-1:0]      col_q;
	logic [11:0]        row_q;
	logic [PW-1:0]      pend_q;

	logic               valid_s1;
	lef_ctl_t           ctl_s1;
	logic [CW-1:0]      col_s1;
	logic [PIX_W-1:0]   pix_s1;

	logic [PIX_W-1:0]   win_q    [9];
	logic [PIX_W-1:0]   win_next [9];

	logic [CMPW-1:0]    fw_ext;
	logic [WW-1:0]      w_eff;
	logic [11:0]        h_eff;
	logic [CW-1:0]      c_eff;
	logic [11:0]        r_eff;
	logic               last_col;
	logic               last_row;
	logic               cfg_wr;
	logic               acc_any;
	logic               acc_pix;
	logic               acc_drn;
	logic               adv_s1;
	logic               ram_we;
	logic [2*PIX_W-1:0] ram_rdata;
	logic [PIX_W-1:0]   kern;
	logic [63:0]        nbrs;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// Effective frame size.
	always_comb begin
		fw_ext = CMPW'(frame_width_q);
		if (fw_ext < CMPW'(3)) begin
			w_eff = WW'(3);
		end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(fw_ext);
		end
		h_eff = (frame_height_q < 12'd3) ? 12'd3 : frame_height_q;
	end

	assign adv_s1        = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign acc_any       = s_axis_tvalid && s_axis_tready;
	assign acc_pix       = acc_any && (s_axis_tuser == OP_PIXEL);
	assign acc_drn       = acc_any && (s_axis_tuser == OP_DRAIN);

	// A pixel arriving over pending results starts a new frame at the origin.
	assign c_eff    = (pend_q != '0) ? '0 : col_q;
	assign r_eff    = (pend_q != '0) ? '0 : row_q;
	assign last_col = ({1'b0, WW'(c_eff)} + (WW+1)'(1)) >= {1'b0, w_eff};
	assign last_row = ({1'b0, r_eff} + 13'd1) >= {1'b0, h_eff};

	// Registers and frame position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= 11'd600;
			frame_height_q <= 12'd400;
			col_q          <= '0;
			row_q          <= '0;
			pend_q         <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_WIDTH: begin
					frame_width_q <= cfg_data[10:0];
					col_q         <= '0;
					row_q         <= '0;
					pend_q        <= '0;
				end
				REG_HEIGHT: begin
					frame_height_q <= cfg_data;
					col_q          <= '0;
					row_q          <= '0;
					pend_q         <= '0;
				end
				default: begin
				end
			endcase
		end else if (acc_pix) begin
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q  <= '0;
					pend_q <= PW'(w_eff) + PW'(1);
				end else begin
					row_q  <= r_eff + 12'd1;
					pend_q <= '0;
				end
			end else begin
				col_q  <= CW'(c_eff + CW'(1));
				row_q  <= r_eff;
				pend_q <= '0;
			end
		end else if (acc_drn && (pend_q != '0)) begin
			pend_q <= pend_q - PW'(1);
		end
	end

	// Second stage: control of the item whose line store data is being read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ctl_s1   <= '0;
		end else if (s_axis_tready) begin
			valid_s1        <= acc_pix || (acc_drn && (pend_q != '0));
			ctl_s1.is_pix   <= acc_pix;
			ctl_s1.emit     <= acc_drn || (r_eff >= 12'd2) || ((r_eff == 12'd1) && (c_eff != '0));
			ctl_s1.interior <= acc_pix && (r_eff >= 12'd2) && (c_eff >= CW'(2));
			ctl_s1.last     <= acc_drn && (pend_q == PW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (acc_any) begin
			col_s1 <= c_eff;
			pix_s1 <= s_axis_tdata;
		end
	end

	// Line stores: older row in the upper half, previous row in the lower half.
	assign ram_we = valid_s1 && adv_s1 && ctl_s1.is_pix;

	lef_ram #(
		.WIDTH (2*PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_s1),
		.wdata ({ram_rdata[PIX_W-1:0], pix_s1}),
		.re    (acc_pix),
		.raddr (c_eff),
		.rdata (ram_rdata)
	);

	// Shift the window left by one column and insert the new column.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			win_next[k*3]     = win_q[k*3+1];
			win_next[k*3 + 1] = win_q[k*3+2];
		end
		win_next[2] = ram_rdata[2*PIX_W-1:PIX_W];
		win_next[5] = ram_rdata[PIX_W-1:0];
		win_next[8] = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= '0;
			end
		end else if (ram_we) begin
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= win_next[k];
			end
		end
	end

	always_comb begin
		nbrs = '0;
		kern = '0;
		for (int ch = 0; ch < 3; ch++) begin
			nbrs = {win_next[8][8*ch +: 8], win_next[7][8*ch +: 8],
				win_next[6][8*ch +: 8], win_next[5][8*ch +: 8],
				win_next[3][8*ch +: 8], win_next[2][8*ch +: 8],
				win_next[1][8*ch +: 8], win_next[0][8*ch +: 8]};
			kern[8*ch +: 8] = lap_chan(win_next[4][8*ch +: 8], nbrs);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
			m_axis_tlast  <= 1'b0;
		end else if (adv_s1) begin
			m_axis_tvalid <= valid_s1 && ctl_s1.emit;
			m_axis_tlast  <= ctl_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			m_axis_tdata <= ctl_s1.interior ? kern : '0;
		end
	end

	`ASSERT_IMPL(a_pend_at_origin, clk, arst_n, pend_q != '0, (col_q == '0) && (row_q == '0))
	`ASSERT_IMPL(a_ram_no_overlap, clk, arst_n, ram_we && acc_pix, col_s1 != c_eff)
	`ASSERT_IMPL(a_last_is_zero, clk, arst_n, m_axis_tvalid && m_axis_tlast, m_axis_tdata == '0)
	`ASSERT_IMPL(a_stall_cause, clk, arst_n, !s_axis_tready, valid_s1 && m_axis_tvalid && !m_axis_tready)

endmodule

`default_nettype wire
